// File: rtl/rwev_pkg.sv
// Shared constants and register codes for the rough-wall eddy viscosity core.
`default_nettype none
package rwev_pkg;

	// configuration register indexes
	localparam int CFG_IW = 1;
	localparam logic [CFG_IW-1:0] REG_CMU   = 1'd0;
	localparam logic [CFG_IW-1:0] REG_KAPPA = 1'd1;

	// register reset values, Q0.16
	localparam logic [15:0] CMU_RST   = 16'd5898;
	localparam logic [15:0] KAPPA_RST = 16'd26870;

	// ln 2 in Q0.24, ln(1 + 1e-4) in Q0.32
	localparam logic [23:0] LN2_Q24      = 24'd11629080;
	localparam logic [37:0] LN_FLOOR_Q32 = 38'd429475;

	// log2 unit: 34-bit argument, Q6.32 result
	localparam int LOG_XW = 34;
	localparam int LOG_FW = 32;
	localparam int LOG_TW = 6;
	localparam int LOG_RW = LOG_TW + LOG_FW;
	localparam int LOG_LAT = 1 + LOG_FW;

	// divider: 56-bit numerator, 38-bit log, 33 quotient bits
	localparam int NUM_W = 56;
	localparam int DEN_W = 38;
	localparam int QUO_W = 33;
	localparam int DIV_LAT = 1 + QUO_W;

	// square roots: cmu^(1/4) takes two 16-bit roots, sqrt(k) one 24-bit root
	localparam int SQ_C_N = 16;
	localparam int SQ_K_N = 24;

	// pipeline schedule (stage numbers counted from the input beat)
	localparam int STG_C4  = 2 * SQ_C_N;        // c4 ready; both logs align with sqrt(k) below
	localparam int SK_DLY  = STG_C4 + 1 - SQ_K_N; // sqrt(k) aligned to stage 33
	localparam int Y_DLY   = STG_C4 + 2;        // wall distance needed at 34
	localparam int DIV_IN  = STG_C4 + 4;        // num and ln registered at 36
	localparam int SIDE_DLY = DIV_IN + DIV_LAT; // quotient at 70
	localparam int PIPE_LAT = SIDE_DLY + 1;     // output register

endpackage
`default_nettype wire

// File: rtl/rwev_delay.sv
// Enable-gated shift line that keeps side data aligned with the pipeline.
`default_nettype none
module rwev_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] tap_q [DEPTH];

	// shift one place per advancing cycle
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule
`default_nettype wire

// File: rtl/rwev_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rwev_isqrt #(
	parameter int N = 16
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [2*N-1:0] x,
	output logic      [N-1:0]   root
);

	localparam int RW = N + 3;

	logic [RW-1:0]  rem_q  [N-1];
	logic [2*N-1:0] x_q    [N-1];
	logic [N-1:0]   root_q [N];

	logic [RW-1:0]  rem_in  [N];
	logic [2*N-1:0] x_in    [N];
	logic [N-1:0]   root_in [N];
	logic [RW-1:0]  rem_sh  [N];
	logic [RW-1:0]  trial   [N];
	logic           ge      [N];
	logic [RW-1:0]  rem_nx  [N];

	// stage inputs and trial subtract
	always_comb begin
		rem_in[0]  = '0;
		x_in[0]    = x;
		root_in[0] = '0;
		for (int i = 1; i < N; i++) begin
			rem_in[i]  = rem_q[i-1];
			x_in[i]    = x_q[i-1];
			root_in[i] = root_q[i-1];
		end
		for (int i = 0; i < N; i++) begin
			rem_sh[i] = {rem_in[i][RW-3:0], x_in[i][2*N-1 -: 2]};
			trial[i]  = {1'b0, root_in[i], 2'b01};
			ge[i]     = rem_sh[i] >= trial[i];
			rem_nx[i] = ge[i] ? rem_sh[i] - trial[i] : rem_sh[i];
		end
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				root_q[i] <= {root_in[i][N-2:0], ge[i]};
			end
			for (int i = 0; i < N - 1; i++) begin
				rem_q[i] <= rem_nx[i];
				x_q[i]   <= {x_in[i][2*N-3:0], 2'b00};
			end
		end
	end

	assign root = root_q[N-1];

endmodule
`default_nettype wire

// File: rtl/rwev_log2.sv
// Pipelined log2 in Q6.32: normalize stage, then one squaring stage per fraction bit.
`default_nettype none
module rwev_log2
	import rwev_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [LOG_XW-1:0] x,
	output logic      [LOG_RW-1:0] lg
);

	logic [LOG_TW-1:0]     top_c;
	logic [LOG_XW+30:0]    sh_c;
	logic [31:0]           m0_s;
	logic [LOG_TW-1:0]     top0_s;

	logic [31:0]           m_q    [LOG_FW-1];
	logic [LOG_FW-1:0]     frac_q [LOG_FW];
	logic [LOG_TW-1:0]     top_q  [LOG_FW];

	logic [31:0]           m_in    [LOG_FW];
	logic [LOG_FW-1:0]     frac_in [LOG_FW];
	logic [LOG_TW-1:0]     top_in  [LOG_FW];
	logic [63:0]           sq_c    [LOG_FW];
	logic [32:0]           t_c     [LOG_FW];
	logic [31:0]           mn_c    [LOG_FW-1];

	// leading-one search and mantissa to Q1.31
	always_comb begin
		top_c = '0;
		for (int b = 0; b < LOG_XW; b++) begin
			if (x[b]) top_c = LOG_TW'(b);
		end
		sh_c = {x, 31'b0} >> top_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m0_s   <= sh_c[31:0];
			top0_s <= top_c;
		end
	end

	// squaring steps
	always_comb begin
		m_in[0]    = m0_s;
		frac_in[0] = '0;
		top_in[0]  = top0_s;
		for (int j = 1; j < LOG_FW; j++) begin
			m_in[j]    = m_q[j-1];
			frac_in[j] = frac_q[j-1];
			top_in[j]  = top_q[j-1];
		end
		for (int j = 0; j < LOG_FW; j++) begin
			sq_c[j] = m_in[j] * m_in[j];
			t_c[j]  = sq_c[j][63:31];
		end
		for (int j = 0; j < LOG_FW - 1; j++) begin
			mn_c[j] = t_c[j][32] ? t_c[j][32:1] : t_c[j][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < LOG_FW; j++) begin
				frac_q[j] <= {frac_in[j][LOG_FW-2:0], t_c[j][32]};
				top_q[j]  <= top_in[j];
			end
			for (int j = 0; j < LOG_FW - 1; j++) begin
				m_q[j] <= mn_c[j];
			end
		end
	end

	assign lg = {top_q[LOG_FW-1], frac_q[LOG_FW-1]};

endmodule
`default_nettype wire

// File: rtl/rwev_div.sv
// Pipelined restoring divider: floor(num * 2^16 / den) with an overflow flag.
`default_nettype none
module rwev_div
	import rwev_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QUO_W-1:0] quo,
	output logic                  ovf
);

	localparam int RW = DEN_W + 1;

	logic [RW-1:0]    r_p_s;
	logic [QUO_W-1:0] n_p_s;
	logic [DEN_W-1:0] d_p_s;
	logic             o_p_s;

	logic [RW-1:0]    r_q [QUO_W-1];
	logic [QUO_W-1:0] n_q [QUO_W-1];
	logic [DEN_W-1:0] d_q [QUO_W-1];
	logic [QUO_W-1:0] q_q [QUO_W];
	logic             o_q [QUO_W];

	logic [RW-1:0]    r_in [QUO_W];
	logic [QUO_W-1:0] n_in [QUO_W];
	logic [DEN_W-1:0] d_in [QUO_W];
	logic [QUO_W-1:0] q_in [QUO_W];
	logic             o_in [QUO_W];
	logic [RW-1:0]    rs_c [QUO_W];
	logic             ge_c [QUO_W];

	// quotient of 2^33 or more cannot fit: flag it, start the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			o_p_s <= num >= ({{(NUM_W-DEN_W){1'b0}}, den} << (QUO_W - 16));
			r_p_s <= num[NUM_W-1:QUO_W-16];
			n_p_s <= {num[QUO_W-17:0], 16'b0};
			d_p_s <= den;
		end
	end

	// one quotient bit per stage
	always_comb begin
		r_in[0] = r_p_s;
		n_in[0] = n_p_s;
		d_in[0] = d_p_s;
		q_in[0] = '0;
		o_in[0] = o_p_s;
		for (int i = 1; i < QUO_W; i++) begin
			r_in[i] = r_q[i-1];
			n_in[i] = n_q[i-1];
			d_in[i] = d_q[i-1];
			q_in[i] = q_q[i-1];
			o_in[i] = o_q[i-1];
		end
		for (int i = 0; i < QUO_W; i++) begin
			rs_c[i] = {r_in[i][RW-2:0], n_in[i][QUO_W-1]};
			ge_c[i] = rs_c[i] >= {1'b0, d_in[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QUO_W; i++) begin
				q_q[i] <= {q_in[i][QUO_W-2:0], ge_c[i]};
				o_q[i] <= o_in[i];
			end
			for (int i = 0; i < QUO_W - 1; i++) begin
				r_q[i] <= ge_c[i] ? rs_c[i] - {1'b0, d_in[i]} : rs_c[i];
				n_q[i] <= {n_in[i][QUO_W-2:0], 1'b0};
				d_q[i] <= d_in[i];
			end
		end
	end

	assign quo = q_q[QUO_W-1];
	assign ovf = o_q[QUO_W-1];

endmodule
`default_nettype wire

// File: rtl/rough_wall_eddy_viscosity_core.sv
// Rough-wall log-law eddy viscosity core. One wall face enters per cycle while the
// pipeline advances; the pipeline depth is set by the log2 unit (one squaring
// stage per fraction bit) followed by the divider (one quotient bit per stage).
// The whole pipeline advances together: it holds only while a finished result
// waits in the output register, and then input ready drops with it.
// cmu and von_karman may only be written while no face is in flight.
`default_nettype none
module rough_wall_eddy_viscosity_core
	import rwev_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [31:0]       tke,
	input  wire logic [31:0]       wall_dist,
	input  wire logic [31:0]       roughness,
	input  wire logic [31:0]       lam_visc,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [31:0]     eddy_visc,
	output logic                   saturated
);

	logic [15:0]          cmu_q;
	logic [15:0]          kappa_q;
	logic [PIPE_LAT-1:0]  vld_q;
	logic                 en;

	logic [SQ_C_N-1:0]    c2_s16;
	logic [SQ_C_N-1:0]    c4_s32;
	logic [SQ_K_N-1:0]    sk_s24;
	logic [SQ_K_N-1:0]    sk_s33;
	logic [31:0]          y_s34;
	logic [LOG_RW-1:0]    la_s33;
	logic [LOG_RW-1:0]    lb_s33;
	logic [32:0]          nu_rnd;
	logic [17:0]          side_s70;

	logic [15:0]          a_s33;
	logic [23:0]          b_s34;
	logic [NUM_W-1:0]     num_s35;
	logic [NUM_W-1:0]     num_s36;
	logic [LOG_RW-1:0]    d_s34;
	logic [LOG_RW+23:0]   lnp_s35;
	logic [DEN_W-1:0]     ln_s36;
	logic [DEN_W-1:0]     lnt_c;
	logic [QUO_W-1:0]     q_s70;
	logic                 ovf_s70;

	logic signed [34:0]   diff_c;
	logic [31:0]          res_s71;
	logic                 sat_s71;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmu_q   <= CMU_RST;
			kappa_q <= KAPPA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CMU:   cmu_q   <= cfg_data;
				REG_KAPPA: kappa_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance and valid line
	assign en       = !vld_q[PIPE_LAT-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	// cmu^(1/4) as two chained roots, sqrt(k) in parallel
	rwev_isqrt #(.N(SQ_C_N)) u_sq_c2 (
		.clk(clk), .en(en), .x({cmu_q, 16'b0}), .root(c2_s16)
	);
	rwev_isqrt #(.N(SQ_C_N)) u_sq_c4 (
		.clk(clk), .en(en), .x({c2_s16, 16'b0}), .root(c4_s32)
	);
	rwev_isqrt #(.N(SQ_K_N)) u_sq_k (
		.clk(clk), .en(en), .x({tke, 16'b0}), .root(sk_s24)
	);
	rwev_delay #(.W(SQ_K_N), .DEPTH(SK_DLY)) u_dly_sk (
		.clk(clk), .en(en), .d(sk_s24), .q(sk_s33)
	);
	rwev_delay #(.W(32), .DEPTH(Y_DLY)) u_dly_y (
		.clk(clk), .en(en), .d(wall_dist), .q(y_s34)
	);

	// log2(y + z0) and log2(z0)
	rwev_log2 u_log_a (
		.clk(clk), .en(en),
		.x({1'b0, {1'b0, wall_dist} + {1'b0, roughness}}),
		.lg(la_s33)
	);
	rwev_log2 u_log_b (
		.clk(clk), .en(en), .x({2'b0, roughness}), .lg(lb_s33)
	);

	// rounded nu and the zero-roughness mark ride alongside
	assign nu_rnd = {1'b0, lam_visc} + 33'd32768;

	rwev_delay #(.W(18), .DEPTH(SIDE_DLY)) u_dly_side (
		.clk(clk), .en(en), .d({roughness == 32'd0, nu_rnd[32:16]}), .q(side_s70)
	);

	// numerator: c4 * kappa * sqrt(k) * y
	always_ff @(posedge clk) begin
		if (en) begin
			a_s33   <= 16'((32'(c4_s32) * 32'(kappa_q)) >> 16);
			b_s34   <= 24'((40'(a_s33) * 40'(sk_s33)) >> 16);
			num_s35 <= 56'(b_s34) * 56'(y_s34);
			num_s36 <= num_s35;
		end
	end

	// ln of the ratio with its floor
	assign lnt_c = lnp_s35[LOG_RW+23:24];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s34   <= (la_s33 > lb_s33) ? la_s33 - lb_s33 : '0;
			lnp_s35 <= (LOG_RW+24)'(d_s34) * (LOG_RW+24)'(LN2_Q24);
			ln_s36  <= (lnt_c < LN_FLOOR_Q32) ? LN_FLOOR_Q32 : lnt_c;
		end
	end

	rwev_div u_div (
		.clk(clk), .en(en), .num(num_s36), .den(ln_s36), .quo(q_s70), .ovf(ovf_s70)
	);

	// subtract nu, clamp, output register
	assign diff_c = $signed({2'b0, q_s70}) - $signed({18'b0, side_s70[16:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s70[17]) begin
				res_s71 <= 32'd0 - {15'b0, side_s70[16:0]};
				sat_s71 <= 1'b0;
			end else if (ovf_s70 || diff_c > 35'sd2147483647) begin
				res_s71 <= 32'h7FFF_FFFF;
				sat_s71 <= 1'b1;
			end else begin
				res_s71 <= diff_c[31:0];
				sat_s71 <= 1'b0;
			end
		end
	end

	assign out_valid = vld_q[PIPE_LAT-1];
	assign eddy_visc = $signed(res_s71);
	assign saturated = sat_s71;

endmodule
`default_nettype wire

// File: verif/rough_wall_eddy_viscosity_core_test.sv
// Testbench for the rough-wall eddy viscosity core: self-checking, directed and randomized stimulus.
`timescale 1ns / 1ps
module rough_wall_eddy_viscosity_core_test;
	import rwev_pkg::*;

	typedef struct {
		logic [31:0] tke;
		logic [31:0] wall_dist;
		logic [31:0] roughness;
		logic [31:0] lam_visc;
	} face_t;

	typedef struct {
		logic signed [31:0] eddy_visc;
		logic               saturated;
	} nut_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IW-1:0] cfg_index = REG_CMU;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] tke = '0, wall_dist = '0, roughness = '0, lam_visc = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] eddy_visc;
	logic saturated;

	face_t pending_faces[$];
	nut_t expected_nut[$];
	logic [15:0] cmu_q = CMU_RST;
	logic [15:0] kappa_q = KAPPA_RST;
	int n_errors = 0;
	int n_results = 0;
	int n_saturated = 0;
	bit idle_on = 1'b1;
	int hold_cycles = 0;
	int gap_in = 0;
	int gap_out = 0;

	rough_wall_eddy_viscosity_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor square root of a 64-bit value
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res, bit_v, rem;
		res = 0;
		rem = v;
		bit_v = 64'd1 << 62;
		while (bit_v > rem)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (rem >= res + bit_v) begin
				rem -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else
				res >>= 1;
			bit_v >>= 2;
		end
		return res;
	endfunction

	// log2 in Q6.32 by repeated squaring of a Q1.31 mantissa
	function automatic logic [63:0] log2_fix(input logic [63:0] x);
		int msb;
		logic [63:0] m, frac;
		frac = 0;
		if (x == 0)
			return 0;
		msb = 63;
		while (msb > 0 && !x[msb])
			msb--;
		m = (msb <= 31) ? (x << (31 - msb)) : (x >> (msb - 31));
		for (int i = 31; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m >>= 1;
				frac[i] = 1'b1;
			end
		end
		return (64'(msb) << 32) | frac;
	endfunction

	// eddy viscosity of one face under the current constants
	function automatic nut_t predict_nut(input face_t f);
		nut_t r;
		logic [63:0] nu16, c4, sk, a, b, num, la, lb, d, lnv, qi, rm, q;
		logic signed [65:0] res;
		nu16 = (64'(f.lam_visc) + 64'd32768) >> 16;
		if (f.roughness == 0)
			res = -$signed({2'b0, nu16});
		else begin
			c4 = isqrt64(isqrt64(64'(cmu_q) << 16) << 16);
			sk = isqrt64(64'(f.tke) << 16);
			a = (c4 * kappa_q) >> 16;
			b = (a * sk) >> 16;
			num = b * f.wall_dist;
			la = log2_fix(64'(f.wall_dist) + f.roughness);
			lb = log2_fix(64'(f.roughness));
			d = (la > lb) ? la - lb : 0;
			lnv = (d * 64'(LN2_Q24)) >> 24;
			if (lnv < 64'(LN_FLOOR_Q32))
				lnv = 64'(LN_FLOOR_Q32);
			qi = num / lnv;
			rm = num % lnv;
			q = (qi << 16) + (rm << 16) / lnv;
			res = $signed({2'b0, q}) - $signed({2'b0, nu16});
		end
		r.saturated = 1'b0;
		if (res > 66'sd2147483647) begin
			res = 66'sd2147483647;
			r.saturated = 1'b1;
		end else if (res < -66'sd2147483648) begin
			res = -66'sd2147483648;
			r.saturated = 1'b1;
		end
		r.eddy_visc = res[31:0];
		return r;
	endfunction

	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 16);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 16);
			2: return $urandom_range(0, 32'h0001_0000);
			3: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_face(input logic [31:0] k, y, z0, nu);
		face_t f;
		f.tke = k;
		f.wall_dist = y;
		f.roughness = z0;
		f.lam_visc = nu;
		pending_faces.push_back(f);
	endtask

	// source side: one beat per handshake, random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_nut.push_back(predict_nut('{tke, wall_dist, roughness, lam_visc}));
				void'(pending_faces.pop_front());
			end
			if (in_valid && !in_ready) begin
				// hold the beat
			end else if (gap_in > 0) begin
				gap_in <= gap_in - 1;
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				gap_in <= $urandom_range(0, 4);
				in_valid <= 1'b0;
			end else if (pending_faces.size() > 0) begin
				face_t f;
				f = pending_faces[0];
				tke <= f.tke;
				wall_dist <= f.wall_dist;
				roughness <= f.roughness;
				lam_visc <= f.lam_visc;
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// sink side: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_nut.size() == 0) begin
					$error("unexpected result beat: eddy_visc %h", eddy_visc);
					n_errors++;
				end else begin
					nut_t e;
					e = expected_nut.pop_front();
					if (eddy_visc !== e.eddy_visc) begin
						$error("eddy_visc expected %h got %h", e.eddy_visc, eddy_visc);
						n_errors++;
					end
					if (saturated !== e.saturated) begin
						$error("saturated expected %b got %b", e.saturated, saturated);
						n_errors++;
					end
					if (e.saturated)
						n_saturated++;
				end
				n_results++;
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else if (gap_out > 0) begin
				gap_out <= gap_out - 1;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				gap_out <= $urandom_range(0, 4);
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic drain();
		while (pending_faces.size() != 0 || in_valid || expected_nut.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CMU)
			cmu_q = val;
		else
			kappa_q = val;
	endtask

	task automatic random_faces(input int n);
		for (int i = 0; i < n; i++) begin
			logic [31:0] z0;
			z0 = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_field();
			queue_face(rand_field(), rand_field(), z0, rand_field());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes and the special cases
		queue_face(32'h0001_0000, 32'h0001_0000, 32'd0, 32'h8000_0000); // no roughness
		queue_face(32'h0004_0000, 32'd0, 32'h0000_1000, 32'hFFFF_FFFF); // zero distance
		queue_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0);         // log term large
		queue_face(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'd0); // ratio near one
		queue_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_face(32'd0, 32'd0, 32'd0, 32'd0);
		queue_face(32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0000_8000);
		queue_face(32'h0100_0000, 32'h0010_0000, 32'h0000_0100, 32'h0000_7FFF);
		queue_face(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		queue_face(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		drain();

		// long receiver hold-off while faces keep coming
		random_faces(300);
		repeat (20) @(posedge clk);
		hold_cycles <= 200;
		drain();

		// sweep the constants, extremes included
		write_reg(REG_CMU, 16'hFFFF);
		write_reg(REG_KAPPA, 16'hFFFF);
		random_faces(400);
		drain();
		write_reg(REG_CMU, 16'd0);
		random_faces(200);
		drain();
		write_reg(REG_CMU, 16'd1);
		write_reg(REG_KAPPA, 16'd0);
		random_faces(200);
		drain();
		write_reg(REG_CMU, 16'($urandom));
		write_reg(REG_KAPPA, 16'($urandom));
		random_faces(400);
		drain();
		write_reg(REG_CMU, CMU_RST);
		write_reg(REG_KAPPA, KAPPA_RST);
		random_faces(200);
		drain();

		// final stretch at full rate
		idle_on = 1'b0;
		random_faces(300);
		drain();

		$display("checked %0d result beats (%0d saturated) over six constant settings",
			n_results, n_saturated);
		$display("with directed edge faces, random gaps and a long output stall");
		if (n_errors == 0)
			$display("rough_wall_eddy_viscosity_core regression: pass");
		else
			$display("rough_wall_eddy_viscosity_core regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("rough_wall_eddy_viscosity_core regression: fail");
		$finish;
	end

endmodule
